@@ rtl/mpfd_pkg.sv @@
// Shared types and constants for the monochrome page frame buffer draw engine.
// Holds the operation codes, controller states and controller/datapath links.
// No dependencies.
package mpfd_pkg;

  // fixed field widths of one input item and one result
  localparam int FUNC_W     = 3;
  localparam int COORD_W    = 8;
  localparam int IDX_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int PAGE_ROWS  = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  // bit offsets of the input fields inside in_tdata
  localparam int FUNC_LSB = 0;
  localparam int X_LSB    = 3;
  localparam int Y_LSB    = 11;
  localparam int W_LSB    = 19;
  localparam int H_LSB    = 27;
  localparam int INK_LSB  = 35;
  localparam int IDX_LSB  = 36;

  // operation codes; the two unused codes do nothing
  typedef enum logic [FUNC_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_PIXEL = 3'd1,
    OP_HLINE = 3'd2,
    OP_RECT  = 3'd3,
    OP_FILL  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input beat
    logic sweep_init;  // set the sweep counters
    logic single;      // sweep covers one byte (pixel)
    logic step;        // issue a read-modify-write and advance
    logic zero;        // this step writes zeros
    logic read_issue;  // read the addressed byte
    logic out_load;    // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  func;
    logic pix_on;   // pixel lies on the screen
    logic last;     // sweep sits at its final byte
    logic wr_pend;  // a write is still outstanding
  } dp_stat_t;

endpackage

@@ rtl/mono_page_framebuffer_draw.sv @@
// Monochrome page-organized frame buffer draw engine, top level.
// One item is worked at a time. Clear, horizontal line, rectangle outline and
// filled rectangle each sweep the whole store one byte per cycle through a
// read-modify-write pipeline on the store's write port and registered read
// port; a pixel sweeps only its own byte (none when off screen), while a read
// byte and the unused codes do not sweep. The result sits in an output
// register, so a new beat is accepted while the previous result waits.
// After reset the store is wiped with in_tready held low.
// Depends on mpfd_pkg, mpfd_ctrl and mpfd_dp.
module mono_page_framebuffer_draw
  import mpfd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // func[2:0], pos_x[10:3], pos_y[18:11], span_w[26:19], span_h[34:27],
  // ink[35], byte_index[44:36], zero pad[47:45]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_byte[7:0]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  mpfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // store and pixel logic
  mpfd_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

@@ rtl/mpfd_dp.sv @@
// Datapath of the frame buffer draw engine: field registers, sweep counters,
// pixel mask logic, the frame store and its read-modify-write pipeline.
// Depends on mpfd_pkg.
module mpfd_dp
  import mpfd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int PAGES      = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_SIZE = SCREEN_WIDTH * PAGES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int COL_W      = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;

  // captured item fields
  op_t                func_r;
  logic [COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic               ink_r;
  logic [IDX_W-1:0]   idx_r;
  logic               idx_ok_r;

  // sweep position
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              single_r;
  logic              col_end;

  // write stage of the read-modify-write pipeline
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [BYTE_W-1:0] wr_mask_r;
  logic              wr_zero_r;
  logic [BYTE_W-1:0] wr_data;

  logic [BYTE_W-1:0] frame_store [STORE_SIZE];
  logic [BYTE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [BYTE_W-1:0]     mask;
  logic [OUT_DATA_W-1:0] out_data_r;

  // field capture on an accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= op_t'(in_tdata[FUNC_LSB +: FUNC_W]);
      x_r      <= in_tdata[X_LSB +: COORD_W];
      y_r      <= in_tdata[Y_LSB +: COORD_W];
      w_r      <= in_tdata[W_LSB +: COORD_W];
      h_r      <= in_tdata[H_LSB +: COORD_W];
      ink_r    <= in_tdata[INK_LSB];
      idx_r    <= in_tdata[IDX_LSB +: IDX_W];
      idx_ok_r <= (int'(in_tdata[IDX_LSB +: IDX_W]) < STORE_SIZE);
    end
  end

  // sweep counters: column, page and linear address advance together
  assign col_end = (col_r == COL_W'(SCREEN_WIDTH - 1));

  always_comb begin
    col_nxt  = col_r;
    page_nxt = page_r;
    addr_nxt = addr_r;
    if (cmd.sweep_init) begin
      if (cmd.single) begin
        col_nxt  = COL_W'(x_r);
        page_nxt = PAGE_W'(y_r >> 3);
        addr_nxt = ADDR_W'(int'(y_r >> 3) * SCREEN_WIDTH + int'(x_r));
      end else begin
        col_nxt  = '0;
        page_nxt = '0;
        addr_nxt = '0;
      end
    end else if (cmd.step) begin
      addr_nxt = addr_r + ADDR_W'(1);
      if (col_end) begin
        col_nxt  = '0;
        page_nxt = page_r + PAGE_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    page_r <= page_nxt;
    addr_r <= addr_nxt;
    if (cmd.sweep_init) begin
      single_r <= cmd.single;
    end
  end

  // pixel mask of the byte at the sweep position, one lane per row bit
  always_comb begin
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] dy;
    logic               in_w;
    logic               edge_col;
    logic               hit;
    dx       = COORD_W'(col_r) - x_r;
    in_w     = (dx < w_r);
    edge_col = (dx == '0) || (dx == w_r - COORD_W'(1));
    mask     = '0;
    for (int b = 0; b < PAGE_ROWS; b++) begin
      row = COORD_W'({page_r, 3'(b)});
      dy  = row - y_r;
      case (func_r)
        OP_PIXEL: hit = (dx == '0) && (dy == '0);
        OP_HLINE: hit = (dy == '0) && in_w;
        OP_RECT:  hit = (((dy == '0) || (dy == h_r - COORD_W'(1))) && in_w) ||
                        (edge_col && (dy < h_r));
        OP_FILL:  hit = in_w && (dy < h_r);
        default:  hit = 1'b0;
      endcase
      mask[b] = hit && (int'(row) < SCREEN_HEIGHT);
    end
  end

  // write stage, in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      wr_addr_r <= addr_r;
      wr_mask_r <= mask;
      wr_zero_r <= cmd.zero;
    end
  end

  assign wr_data = wr_zero_r ? '0 :
                   (ink_r ? (rd_data_r | wr_mask_r) : (rd_data_r & ~wr_mask_r));

  // frame store: one write port, one registered read port
  assign rd_en   = cmd.step || cmd.read_issue;
  assign rd_addr = cmd.read_issue ? ADDR_W'(idx_r) : addr_r;

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      frame_store[wr_addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= frame_store[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= ((func_r == OP_READ) && idx_ok_r) ? rd_data_r : '0;
    end
  end

  assign out_tdata    = out_data_r;
  assign stat.func    = func_r;
  assign stat.pix_on  = (int'(x_r) < SCREEN_WIDTH) && (int'(y_r) < SCREEN_HEIGHT);
  assign stat.last    = single_r ||
                        (col_end && (page_r == PAGE_W'(PAGES - 1)));
  assign stat.wr_pend = wr_pend_r;

endmodule

@@ rtl/mpfd_ctrl.sv @@
// Controller of the frame buffer draw engine: sequences the store wipe after
// reset, the per-operation sweeps, reads and the result handshake.
// Depends on mpfd_pkg.
module mpfd_ctrl
  import mpfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   wipe_r, wipe_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      wipe_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wipe_r       <= wipe_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    wipe_nxt       = wipe_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_SWEEP;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.func)
          OP_CLEAR, OP_HLINE, OP_RECT, OP_FILL: begin
            cmd.sweep_init = 1'b1;
            state_nxt      = ST_SWEEP;
          end
          OP_PIXEL: begin
            if (stat.pix_on) begin
              cmd.sweep_init = 1'b1;
              cmd.single     = 1'b1;
              state_nxt      = ST_SWEEP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_READ: begin
            cmd.read_issue = 1'b1;
            state_nxt      = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        cmd.zero = wipe_r || (stat.func == OP_CLEAR);
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last write lands this cycle
        if (wipe_r) begin
          wipe_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;

  // no beat is taken before the post-reset wipe has finished
  a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !wipe_r)
    else $error("input taken during store wipe");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while an item is in work");

  // store writes only happen inside a sweep
  a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.wr_pend |-> (state_r == ST_SWEEP || state_r == ST_DRAIN))
    else $error("store write outside a sweep");

  // a finished item with a free output slot shows its result next cycle
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_tvalid_r) |=> out_tvalid_r)
    else $error("result not presented");

endmodule

@@ sim/mpfd_checker.sv @@
// Checker for the monochrome page frame buffer draw engine.
// Watches both stream channels, keeps its own copy of the frame store and compares
// every result beat with the predicted read byte. Depends on mpfd_pkg.
`timescale 1ns / 1ps

module mpfd_checker
  import mpfd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  localparam int PAGES       = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int SHOW_LIMIT  = 10;

  // shadow of the frame store and the read bytes still owed by the block
  logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
  logic [BYTE_W-1:0] byte_due_q [$];

  // set or clear one pixel, dropping it when off the screen
  function automatic void plot_pixel(logic [7:0] px, logic [7:0] py, logic ink);
    int addr;
    if (int'(px) >= SCREEN_WIDTH || int'(py) >= SCREEN_HEIGHT) return;
    addr = (int'(py) / PAGE_ROWS) * SCREEN_WIDTH + int'(px);
    if (addr >= STORE_BYTES) return;
    shadow_store[addr][py[2:0]] = ink;
  endfunction

  // horizontal run of len pixels, column wraps modulo 256
  function automatic void plot_run(logic [7:0] x0, logic [7:0] row, logic [7:0] len,
                                   logic ink);
    logic [7:0] cx;
    cx = x0;
    for (int i = 0; i < int'(len); i++) begin
      plot_pixel(cx, row, ink);
      cx = cx + 8'd1;
    end
  endfunction

  // apply one drawing command to the shadow and return the byte it reads back
  function automatic logic [BYTE_W-1:0] draw_and_read(logic [IN_DATA_W-1:0] beat);
    op_t        op;
    logic [7:0] x, y, w, h, bottom, right;
    logic       ink;
    logic [8:0] idx;
    logic [7:0] rd;
    op     = op_t'(beat[FUNC_LSB +: FUNC_W]);
    x      = beat[X_LSB +: COORD_W];
    y      = beat[Y_LSB +: COORD_W];
    w      = beat[W_LSB +: COORD_W];
    h      = beat[H_LSB +: COORD_W];
    ink    = beat[INK_LSB];
    idx    = beat[IDX_LSB +: IDX_W];
    bottom = y + h - 8'd1;
    right  = x + w - 8'd1;
    rd     = '0;
    case (op)
      OP_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      OP_PIXEL: plot_pixel(x, y, ink);
      OP_HLINE: plot_run(x, y, w, ink);
      OP_RECT: begin
        plot_run(x, y, w, ink);
        plot_run(x, bottom, w, ink);
        for (int i = 0; i < int'(h); i++) begin
          plot_pixel(x, y + 8'(i), ink);
          plot_pixel(right, y + 8'(i), ink);
        end
      end
      OP_FILL: begin
        for (int i = 0; i < int'(h); i++) plot_run(x, y + 8'(i), w, ink);
      end
      OP_READ: begin
        if (int'(idx) < STORE_BYTES) rd = shadow_store[idx];
      end
      default: ;
    endcase
    return rd;
  endfunction

  // result beats are matched first, then the new command is predicted
  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      byte_due_q.delete();
      fail_count   <= 0;
      pending      <= 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (byte_due_q.size() == 0) begin
          if (fail_count < SHOW_LIMIT)
            $display("%0t: result beat 0x%02h with nothing outstanding", $realtime, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = byte_due_q.pop_front();
          if (out_tdata[BYTE_W-1:0] !== want) begin
            if (fail_count < SHOW_LIMIT)
              $display("%0t: read_byte mismatch, expected 0x%02h got 0x%02h",
                       $realtime, want, out_tdata[BYTE_W-1:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) byte_due_q.push_back(draw_and_read(in_tdata));
      pending <= byte_due_q.size();
    end
  end

endmodule

@@ sim/tb_mono_page_framebuffer_draw.sv @@
// Testbench top for the monochrome page frame buffer draw engine.
// Drives directed then random drawing commands with bursty input and a stalling
// result side; mpfd_checker does the prediction. Depends on mpfd_pkg and the block.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw;
  import mpfd_pkg::*;

  localparam int SCR_W        = 128;
  localparam int SCR_H        = 32;
  localparam int RAND_ITEMS   = 1275;
  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 3000;
  localparam int TAIL_CYCLES  = 600;
  // spare function codes, the block leaves the store alone for these
  localparam logic [FUNC_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // func[2:0], pos_x[10:3], pos_y[18:11], span_w[26:19], span_h[34:27],
  // ink[35], byte_index[44:36], zero pad[47:45]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // read_byte[7:0]
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int results_seen;
  int idle_cycles;

  // last on-screen spot drawn, so reads often land on fresh pixels
  logic [7:0] aim_x;
  logic [7:0] aim_y;

  mono_page_framebuffer_draw #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  mpfd_checker #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // pack one command beat
  function automatic logic [IN_DATA_W-1:0] pack_cmd(logic [FUNC_W-1:0] f, logic [7:0] x,
                                                    logic [7:0] y, logic [7:0] w,
                                                    logic [7:0] h, logic ink,
                                                    logic [IDX_W-1:0] idx);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[FUNC_LSB +: FUNC_W] = f;
    beat[X_LSB +: COORD_W]   = x;
    beat[Y_LSB +: COORD_W]   = y;
    beat[W_LSB +: COORD_W]   = w;
    beat[H_LSB +: COORD_W]   = h;
    beat[INK_LSB]            = ink;
    beat[IDX_LSB +: IDX_W]   = idx;
    return beat;
  endfunction

  // random command: mostly on-screen shapes of modest size, now and then anything
  function automatic logic [IN_DATA_W-1:0] random_cmd();
    int               pick;
    logic [FUNC_W-1:0] f;
    logic [7:0]       x, y, w, h;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 3)       f = OP_CLEAR;
    else if (pick < 33) f = OP_PIXEL;
    else if (pick < 45) f = OP_HLINE;
    else if (pick < 55) f = OP_RECT;
    else if (pick < 65) f = OP_FILL;
    else if (pick < 97) f = OP_READ;
    else                f = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    x   = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, SCR_W - 1));
    y   = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                         : $urandom_range(0, SCR_H - 1));
    w   = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24));
    h   = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12));
    idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    if (f == OP_READ && $urandom_range(0, 1) != 0)
      idx = IDX_W'((int'(aim_y) / PAGE_ROWS) * SCR_W + int'(aim_x));
    if (f != OP_READ && int'(x) < SCR_W && int'(y) < SCR_H) begin
      aim_x = x;
      aim_y = y;
    end
    return pack_cmd(f, x, y, w, h, 1'($urandom_range(0, 1)), idx);
  endfunction

  // offer one beat and hold it until the block takes it
  task automatic offer_beat(input logic [IN_DATA_W-1:0] beat);
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // result side: stall patterns in stretches, plus one long hold-off
  initial begin
    int mode;
    int len;
    int tick;
    bit held;
    held = 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 400);
      repeat (len) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ((tick % 7) < 3);
        endcase
      end
      if (!held && results_seen >= 400) begin
        held = 1'b1;
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // reset, directed commands, random commands, drain and verdict
  initial begin
    logic [IN_DATA_W-1:0] directed_q [$];
    int burst;
    int gap;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    aim_x       = '0;
    aim_y       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // store starts cleared, single pixels at corners and off screen
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd127, 8'd31, 8'd0, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd0, 8'd32, 8'd0, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 9'd511));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd511));
    // lines clipped at the right edge, wrapped past 255, and of zero width
    directed_q.push_back(pack_cmd(OP_HLINE, 8'd120, 8'd9, 8'd20, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_HLINE, 8'd250, 8'd10, 8'd12, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_HLINE, 8'd5, 8'd3, 8'd0, 8'd0, 1'b1, 9'd0));
    // outlines with zero width, zero height, and wrapping corners
    directed_q.push_back(pack_cmd(OP_RECT, 8'd10, 8'd4, 8'd0, 8'd6, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_RECT, 8'd20, 8'd2, 8'd8, 8'd0, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_RECT, 8'd250, 8'd250, 8'd20, 8'd20, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd1));
    // full-range fill, then a cleared hole
    directed_q.push_back(pack_cmd(OP_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 9'd0));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd300));
    directed_q.push_back(pack_cmd(OP_FILL, 8'd30, 8'd5, 8'd40, 8'd10, 1'b0, 9'd0));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd296));
    directed_q.push_back(pack_cmd(OP_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0));
    directed_q.push_back(pack_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0));
    // spare codes leave the store alone
    directed_q.push_back(pack_cmd(OP_SPARE_LO, 8'd3, 8'd3, 8'd9, 8'd9, 1'b0, 9'd3));
    directed_q.push_back(pack_cmd(OP_SPARE_HI, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 9'd511));
    directed_q.push_back(pack_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0));
    directed_q.push_back(pack_cmd(OP_RECT, 8'd0, 8'd0, 8'd128, 8'd32, 1'b1, 9'd0));
    foreach (directed_q[i]) offer_beat(directed_q[i]);

    // random commands in bursts with gaps of varied length
    burst = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 700) : $urandom_range(0, 8);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      offer_beat(random_cmd());
      burst--;
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then give the block time to misbehave
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mpfd_pkg.sv
rtl/mpfd_dp.sv
rtl/mpfd_ctrl.sv
rtl/mono_page_framebuffer_draw.sv
sim/mpfd_checker.sv
sim/tb_mono_page_framebuffer_draw.sv
